// ===== rtl/smeu_pkg.sv =====
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared constants, codes and types for the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

  // storage sizes
  localparam int STACK_DEPTH = 256;
  localparam int MEM_WORDS   = 256;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int MEM_AW      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int SP_W        = 9;
  localparam int WORD_W      = 32;

  // opcodes
  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_PUSH  = 8'd1;
  localparam logic [7:0] OP_POP   = 8'd2;
  localparam logic [7:0] OP_DUP   = 8'd3;
  localparam logic [7:0] OP_ADD   = 8'd4;
  localparam logic [7:0] OP_SUB   = 8'd5;
  localparam logic [7:0] OP_MUL   = 8'd6;
  localparam logic [7:0] OP_DIV   = 8'd7;
  localparam logic [7:0] OP_CMP   = 8'd8;
  localparam logic [7:0] OP_WRMEM = 8'd9;
  localparam logic [7:0] OP_LOAD  = 8'd10;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_OVERFLOW   = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW  = 3'd2;
  localparam logic [2:0] ST_BADOP      = 3'd3;
  localparam logic [2:0] ST_DIVZERO    = 3'd4;
  localparam logic [2:0] ST_MEMBOUNDS  = 3'd5;
  localparam logic [2:0] ST_CODEBOUNDS = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_TOS, S_LOAD, S_OPA, S_DIV, S_WB, S_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes decoded stack machine instructions against an operand stack and
// a word data memory, one transaction in, one status transaction out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one decoded instruction per transaction; the
//   master channel m_* returns status, halt flag, top of stack and depth.
//   The operand stack and the data memory are synchronous RAMs with
//   registered reads; the top of stack is also held in a register.
//   From acceptance to m_*: halt, push, dup, ignored instructions and most
//   errors go from execute to done; pop, store and a divide by zero reload
//   the top first (not when the stack ends up empty); load pushes the word;
//   add, sub, mul and cmp fetch the operand and write back; div also runs
//   the 32-step divider, the slowest path. One instruction is in flight at
//   a time; the next is taken the cycle after the result is registered.
//   s_tready is high in idle, also while an earlier result still waits.
//   If the receiver stalls, the result is held in the output register and
//   the next instruction finishes but waits before its result is loaded.
//   Reset empties the stack, zeroes the data memory (per-word valid flags),
//   clears the error code and halt flag; no clearing pass is needed. A
//   restart transaction does the same and returns a result.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit
  import smeu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[7:0], immediate[39:8], immediate_missing[40], restart[41], zero
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], halted[3], top_value[35:4], stack_depth[44:36], zero
  output logic [47:0] m_tdata
);

  state_t state, state_next;

  // latched instruction
  logic [7:0]        op;
  logic [WORD_W-1:0] imm;
  logic              miss;
  logic              rstrt;

  // architectural state
  logic [SP_W-1:0]   sp, sp_next;
  logic [WORD_W-1:0] tos, tos_next;
  logic [2:0]        err, err_next;
  logic              stopped, stopped_next;
  logic [WORD_W-1:0] opb, opb_next;
  logic [WORD_W-1:0] res, res_next;

  // memories
  logic [WORD_W-1:0] stk [STACK_DEPTH];
  logic [WORD_W-1:0] dmem [MEM_WORDS];
  logic [MEM_WORDS-1:0] dval;
  logic              stk_we;
  logic [STK_AW-1:0] stk_wa;
  logic [WORD_W-1:0] stk_wd;
  logic [WORD_W-1:0] stk_rd;
  logic              dm_we;
  logic              dval_clr;
  logic [WORD_W-1:0] dm_rd;
  logic              dm_rd_ok;
  logic [MEM_AW-1:0] dm_idx;
  logic [SP_W-1:0]   sp_m2;

  // decode helpers
  logic sp_zero, sp_one, sp_full, idx_ok, ignore, is_bin, is_div;
  logic div_start;
  div_rsp_t div_rsp;

  assign sp_zero = (sp == '0);
  assign sp_one  = (sp == SP_W'(1));
  assign sp_full = (sp >= SP_W'(STACK_DEPTH));
  assign idx_ok  = !imm[WORD_W-1] && (imm[WORD_W-2:0] < (WORD_W-1)'(MEM_WORDS));
  assign ignore  = rstrt || stopped || miss;
  assign is_bin  = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
                   (op == OP_DIV) || (op == OP_CMP);
  assign is_div  = (op == OP_DIV);
  assign sp_m2   = sp - SP_W'(2);
  assign dm_idx  = imm[MEM_AW-1:0];

  assign s_tready = (state == S_IDLE);

  // stack ram: read below the top every cycle
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_wa] <= stk_wd;
    end
    stk_rd <= stk[sp_m2[STK_AW-1:0]];
  end

  // data ram
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_idx] <= tos;
    end
    dm_rd <= dmem[dm_idx];
  end

  // data ram valid flags, cleared by reset and restart
  always_ff @(posedge clk) begin
    if (rst || dval_clr) begin
      dval <= '0;
    end else if (dm_we) begin
      dval[dm_idx] <= 1'b1;
    end
    dm_rd_ok <= dval[dm_idx];
  end

  // instruction capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op    <= s_tdata[7:0];
      imm   <= s_tdata[39:8];
      miss  <= s_tdata[40];
      rstrt <= s_tdata[41];
    end
  end

  smeu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (stk_rd),
    .divisor  (opb),
    .rsp      (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (!ignore) begin
          if (op == OP_POP) begin
            if (!sp_zero && !sp_one) state_next = S_TOS;
          end else if (op == OP_WRMEM) begin
            if (idx_ok && !sp_zero && !sp_one) state_next = S_TOS;
          end else if (op == OP_LOAD) begin
            if (idx_ok && !sp_full) state_next = S_LOAD;
          end else if (is_bin && !sp_zero) begin
            if (is_div && tos == '0) begin
              if (!sp_one) state_next = S_TOS;
            end else if (!sp_one) begin
              state_next = S_OPA;
            end
          end
        end
      end
      S_TOS:  state_next = S_DONE;
      S_LOAD: state_next = S_DONE;
      S_OPA:  state_next = is_div ? S_DIV : S_WB;
      S_DIV: begin
        if (div_rsp.done) state_next = S_WB;
      end
      S_WB:   state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    sp_next      = sp;
    tos_next     = tos;
    err_next     = err;
    stopped_next = stopped;
    opb_next     = opb;
    res_next     = res;
    stk_we       = 1'b0;
    stk_wa       = sp[STK_AW-1:0];
    stk_wd       = imm;
    dm_we        = 1'b0;
    dval_clr     = 1'b0;
    div_start    = 1'b0;
    unique case (state)
      S_EXEC: begin
        if (rstrt) begin
          sp_next      = '0;
          err_next     = ST_OK;
          stopped_next = 1'b0;
          dval_clr     = 1'b1;
        end else if (stopped) begin
          sp_next = sp;
        end else if (miss) begin
          err_next     = ST_CODEBOUNDS;
          stopped_next = 1'b1;
        end else begin
          unique case (op) inside
            OP_HALT: stopped_next = 1'b1;
            OP_PUSH: begin
              if (sp_full) begin
                err_next     = ST_OVERFLOW;
                stopped_next = 1'b1;
              end else begin
                stk_we   = 1'b1;
                tos_next = imm;
                sp_next  = sp + SP_W'(1);
              end
            end
            OP_POP: begin
              if (sp_zero) begin
                err_next     = ST_UNDERFLOW;
                stopped_next = 1'b1;
              end else begin
                sp_next = sp - SP_W'(1);
              end
            end
            OP_DUP: begin
              if (sp_zero) begin
                err_next     = ST_UNDERFLOW;
                stopped_next = 1'b1;
              end else if (sp_full) begin
                err_next     = ST_OVERFLOW;
                stopped_next = 1'b1;
              end else begin
                stk_we  = 1'b1;
                stk_wd  = tos;
                sp_next = sp + SP_W'(1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
              opb_next = tos;
              if (sp_zero) begin
                err_next     = ST_UNDERFLOW;
                stopped_next = 1'b1;
              end else if (is_div && tos == '0) begin
                err_next     = ST_DIVZERO;
                stopped_next = 1'b1;
                sp_next      = sp - SP_W'(1);
              end else if (sp_one) begin
                err_next     = ST_UNDERFLOW;
                stopped_next = 1'b1;
                sp_next      = '0;
              end else begin
                sp_next = sp_m2;
              end
            end
            OP_WRMEM: begin
              if (!idx_ok) begin
                err_next     = ST_MEMBOUNDS;
                stopped_next = 1'b1;
              end else if (sp_zero) begin
                err_next     = ST_UNDERFLOW;
                stopped_next = 1'b1;
              end else begin
                dm_we   = 1'b1;
                sp_next = sp - SP_W'(1);
              end
            end
            OP_LOAD: begin
              if (!idx_ok) begin
                err_next     = ST_MEMBOUNDS;
                stopped_next = 1'b1;
              end else if (sp_full) begin
                err_next     = ST_OVERFLOW;
                stopped_next = 1'b1;
              end
            end
            default: begin
              err_next     = ST_BADOP;
              stopped_next = 1'b1;
            end
          endcase
        end
      end
      // reload the cached top after a pop, a store or a divide by zero
      S_TOS: tos_next = stk_rd;
      // push the loaded word, unwritten words read as zero
      S_LOAD: begin
        stk_we   = 1'b1;
        stk_wd   = dm_rd_ok ? dm_rd : '0;
        tos_next = stk_wd;
        sp_next  = sp + SP_W'(1);
      end
      // second operand has arrived
      S_OPA: begin
        case (op)
          OP_ADD:  res_next = stk_rd + opb;
          OP_SUB:  res_next = stk_rd - opb;
          OP_MUL:  res_next = stk_rd * opb;
          OP_CMP:  res_next = ($signed(stk_rd) < $signed(opb)) ? WORD_W'(1) : '0;
          default: div_start = 1'b1;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) res_next = div_rsp.quotient;
      end
      S_WB: begin
        stk_we   = 1'b1;
        stk_wd   = res;
        tos_next = res;
        sp_next  = sp + SP_W'(1);
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sp      <= '0;
      err     <= ST_OK;
      stopped <= 1'b0;
    end else begin
      state   <= state_next;
      sp      <= sp_next;
      err     <= err_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    opb <= opb_next;
    res <= res_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, sp, (sp_zero ? WORD_W'(0) : tos), stopped, err};
    end
  end

endmodule

// ===== rtl/smeu_div.sv =====
// ----------------------------------------------------------------------------
// smeu_div
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module smeu_div
  import smeu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output div_rsp_t          rsp
);

  logic                      busy;
  logic                      done;
  logic [4:0]                cnt;
  logic                      neg;
  logic [WORD_W-1:0]         rem;
  logic [WORD_W-1:0]         quo;
  logic [WORD_W-1:0]         den;
  logic [WORD_W:0]           r2;
  logic [WORD_W:0]           diff;
  logic                      ge;

  // one restoring step
  assign r2   = {rem, quo[WORD_W-1]};
  assign diff = r2 - {1'b0, den};
  assign ge   = (r2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // operand magnitudes and iteration
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= 5'd0;
      rem <= '0;
      quo <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      den <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      neg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      rem <= ge ? diff[WORD_W-1:0] : r2[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? (WORD_W'(0) - quo) : quo;

endmodule

// ===== rtl/smeu_checker.sv =====
// ----------------------------------------------------------------------------
// smeu_props
// Port-level checks on the stack machine execute unit.
// ----------------------------------------------------------------------------
module smeu_props (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one instruction in flight
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");

  // any error stops the machine
  a_err_halt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] == 3'd0 || m_tdata[3]))
    else $error("error reported without halt");

  // depth never beyond the stack size
  a_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[44] && (m_tdata[43:36] != 8'd0)))
    else $error("stack depth out of range");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind stack_machine_execute_unit smeu_props u_smeu_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
